// ===== rtl/qtl_pkg.sv =====
// ----------------------------------------------------------------------------
// qtl_pkg
// Shared types and constants of the tabular Q-learning engine.
// ----------------------------------------------------------------------------
`default_nettype none

package qtl_pkg;

  // field widths fixed by the item format
  localparam int STATE_W = 10;
  localparam int MOVE_W  = 3;
  localparam int VALUE_W = 32;
  localparam int FRAC_W  = 16;
  localparam int COUNT_W = 4;

  // configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 16;

  localparam logic [CFG_IW-1:0] REG_DISCOUNT    = 2'd0;
  localparam logic [CFG_IW-1:0] REG_EXPLORATION = 2'd1;
  localparam logic [CFG_IW-1:0] REG_MOVE_COUNT  = 2'd2;

  localparam logic [FRAC_W-1:0]  DISCOUNT_RST    = 16'd58982;
  localparam logic [FRAC_W-1:0]  EXPLORATION_RST = 16'd6554;
  localparam logic [COUNT_W-1:0] MOVE_COUNT_RST  = 4'd4;

  // operation codes
  localparam logic ACT_CHOOSE = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  // reduction step counter width (wide enough for the reduction steps of a 10-bit index)
  localparam int RED_KW = 4;

  typedef struct packed {
    logic                      action;
    logic [STATE_W-1:0]        current_state;
    logic [STATE_W-1:0]        next_state;
    logic [MOVE_W-1:0]         move;
    logic signed [VALUE_W-1:0] reward;
    logic [FRAC_W-1:0]         learning_rate;
    logic [FRAC_W-1:0]         random_fraction;
    logic [MOVE_W-1:0]         random_move;
  } qtl_in_t;

  typedef struct packed {
    logic [MOVE_W-1:0]         chosen_move;
    logic                      explored;
    logic signed [VALUE_W-1:0] new_value;
  } qtl_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_MUL,
    ST_TARGET,
    ST_DIFF,
    ST_SCALE,
    ST_SAT,
    ST_WRITE,
    ST_DONE
  } qtl_state_t;

  // step enables of the update datapath
  typedef struct packed {
    logic load_q;
    logic load_t;
    logic load_d;
    logic load_p;
    logic load_n;
  } qtl_arith_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/q_table_learner.sv =====
// ----------------------------------------------------------------------------
// q_table_learner
// Tabular Q-learning engine with epsilon-greedy move choice.
// ----------------------------------------------------------------------------
// After reset the table is zeroed by a clearing pass over all
// STATE_COUNT*MAX_MOVES entries, during which no item is taken (configuration
// writes are). One item is worked at a time. A choose item passes through the
// steps that fold a state index into STATE_COUNT (none when STATE_COUNT is 1024
// or more) and the maximum search; an update item goes on through the update.
// The pace is set by the single read port of the table memory, which reads one
// move of a state per cycle for the maximum search, and by the six-step update
// datapath that follows it. The finished result sits in an output register, so
// a new item is taken while it waits to be collected.
// ----------------------------------------------------------------------------
`default_nettype none

module q_table_learner #(
  parameter int STATE_COUNT = 1024,
  parameter int MAX_MOVES   = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire qtl_pkg::qtl_in_t            in_data,
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      qtl_pkg::qtl_out_t           out_data,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [qtl_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [qtl_pkg::CFG_DW-1:0]  cfg_data
);

  localparam int SW    = $clog2(STATE_COUNT);
  localparam int MW    = $clog2(MAX_MOVES);
  localparam int CW    = $clog2(MAX_MOVES + 1);
  localparam int DEPTH = STATE_COUNT * MAX_MOVES;
  localparam int AW    = $clog2(DEPTH);

  // number of conditional subtracts that bring a 10-bit index below STATE_COUNT
  function automatic int red_steps_f();
    int n;
    n = 0;
    for (int k = 0; k < qtl_pkg::STATE_W; k++) begin
      if ((STATE_COUNT << k) < (1 << qtl_pkg::STATE_W)) begin
        n = n + 1;
      end
    end
    return n;
  endfunction

  localparam int RED_STEPS = red_steps_f();

  qtl_pkg::qtl_state_t state, state_next;

  // configuration registers
  logic [qtl_pkg::FRAC_W-1:0]  discount;
  logic [qtl_pkg::FRAC_W-1:0]  exploration;
  logic [qtl_pkg::COUNT_W-1:0] move_count;

  // item registers
  logic                               act;
  logic [qtl_pkg::STATE_W-1:0]        cur_red;
  logic [qtl_pkg::STATE_W-1:0]        nxt_red;
  logic [MW-1:0]                      mv_c;
  logic [MW-1:0]                      rnd_c;
  logic signed [qtl_pkg::VALUE_W-1:0] reward;
  logic [qtl_pkg::FRAC_W-1:0]         alpha;
  logic [qtl_pkg::FRAC_W-1:0]         frac;

  logic [qtl_pkg::RED_KW-1:0] red_k;
  logic [MW-1:0]              scan_idx;
  logic                       scan_hit;
  logic [MW-1:0]              hit_idx;
  logic signed [qtl_pkg::VALUE_W-1:0] best;
  logic [MW-1:0]              best_arg;
  logic [AW-1:0]              clr_addr;

  // memory port signals
  logic                        we;
  logic [AW-1:0]               waddr;
  logic [qtl_pkg::VALUE_W-1:0] wdata;
  logic [AW-1:0]               raddr;
  logic [qtl_pkg::VALUE_W-1:0] rdata;

  logic signed [qtl_pkg::VALUE_W-1:0] nv;
  qtl_pkg::qtl_arith_ctl_t actl;

  logic [4:0]    mc5;
  logic [CW-1:0] mc_eff;
  logic [4:0]    mv5;
  logic [4:0]    rnd5;
  logic          scan_last;
  logic [SW-1:0] cur_s;
  logic [SW-1:0] scan_s;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] scan_addr;
  logic [31:0]   thr;
  logic          accept;
  logic          out_free;

  // effective move count: zero acts as one, capped at MAX_MOVES
  always_comb begin
    if (move_count == '0) begin
      mc5 = 5'd1;
    end else if ({1'b0, move_count} > 5'(MAX_MOVES)) begin
      mc5 = 5'(MAX_MOVES);
    end else begin
      mc5 = {1'b0, move_count};
    end
  end
  assign mc_eff = CW'(mc5);

  // moves clipped to the count in use
  assign mv5  = 5'(in_data.move);
  assign rnd5 = 5'(in_data.random_move);

  assign cur_s     = SW'(cur_red);
  assign scan_s    = (act == qtl_pkg::ACT_UPDATE) ? SW'(nxt_red) : cur_s;
  assign cur_addr  = AW'(cur_s) * AW'(MAX_MOVES) + AW'(mv_c);
  assign scan_addr = AW'(scan_s) * AW'(MAX_MOVES) + AW'(scan_idx);
  assign scan_last = (5'(scan_idx) == (5'(mc_eff) - 5'd1));
  assign thr       = 32'(STATE_COUNT) << red_k;
  assign out_free  = !out_valid || !out_stall;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      discount    <= qtl_pkg::DISCOUNT_RST;
      exploration <= qtl_pkg::EXPLORATION_RST;
      move_count  <= qtl_pkg::MOVE_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        qtl_pkg::REG_DISCOUNT:    discount    <= cfg_data;
        qtl_pkg::REG_EXPLORATION: exploration <= cfg_data;
        qtl_pkg::REG_MOVE_COUNT:  move_count  <= cfg_data[qtl_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qtl_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and control outputs
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    we         = 1'b0;
    waddr      = cur_addr;
    wdata      = nv;
    raddr      = cur_addr;
    actl       = '0;
    case (state)
      qtl_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = qtl_pkg::ST_IDLE;
        end
      end
      qtl_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = (RED_STEPS == 0) ? qtl_pkg::ST_SCAN : qtl_pkg::ST_REDUCE;
        end
      end
      qtl_pkg::ST_REDUCE: begin
        if (red_k == '0) begin
          state_next = qtl_pkg::ST_SCAN;
        end
      end
      qtl_pkg::ST_SCAN: begin
        raddr = scan_addr;
        if (scan_last) begin
          state_next = qtl_pkg::ST_SCAN_LAST;
        end
      end
      qtl_pkg::ST_SCAN_LAST: begin
        state_next = (act == qtl_pkg::ACT_UPDATE) ? qtl_pkg::ST_MUL : qtl_pkg::ST_DONE;
      end
      qtl_pkg::ST_MUL: begin
        actl.load_q = 1'b1;
        state_next  = qtl_pkg::ST_TARGET;
      end
      qtl_pkg::ST_TARGET: begin
        actl.load_t = 1'b1;
        state_next  = qtl_pkg::ST_DIFF;
      end
      qtl_pkg::ST_DIFF: begin
        actl.load_d = 1'b1;
        state_next  = qtl_pkg::ST_SCALE;
      end
      qtl_pkg::ST_SCALE: begin
        actl.load_p = 1'b1;
        state_next  = qtl_pkg::ST_SAT;
      end
      qtl_pkg::ST_SAT: begin
        actl.load_n = 1'b1;
        state_next  = qtl_pkg::ST_WRITE;
      end
      qtl_pkg::ST_WRITE: begin
        we         = 1'b1;
        state_next = qtl_pkg::ST_DONE;
      end
      qtl_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = qtl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = qtl_pkg::ST_IDLE;
      end
    endcase
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == qtl_pkg::ST_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // capture item, fold state indices, step the scan counter
  always_ff @(posedge clk) begin
    if (accept) begin
      act      <= in_data.action;
      cur_red  <= in_data.current_state;
      nxt_red  <= in_data.next_state;
      mv_c     <= (mv5 >= mc5) ? MW'(mc5 - 5'd1) : MW'(mv5);
      rnd_c    <= (rnd5 >= mc5) ? MW'(mc5 - 5'd1) : MW'(rnd5);
      reward   <= in_data.reward;
      alpha    <= in_data.learning_rate;
      frac     <= in_data.random_fraction;
      red_k    <= qtl_pkg::RED_KW'(RED_STEPS - 1);
      scan_idx <= '0;
    end
    if (state == qtl_pkg::ST_REDUCE) begin
      if (32'(cur_red) >= thr) begin
        cur_red <= qtl_pkg::STATE_W'(32'(cur_red) - thr);
      end
      if (32'(nxt_red) >= thr) begin
        nxt_red <= qtl_pkg::STATE_W'(32'(nxt_red) - thr);
      end
      red_k <= red_k - qtl_pkg::RED_KW'(1);
    end
    if (state == qtl_pkg::ST_SCAN) begin
      scan_idx <= scan_idx + MW'(1);
    end
  end

  // read data of a scan beat arrives in the cycle after its address
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_hit <= 1'b0;
    end else begin
      scan_hit <= (state == qtl_pkg::ST_SCAN);
    end
  end

  // running maximum, first move wins on ties
  always_ff @(posedge clk) begin
    hit_idx <= scan_idx;
    if (scan_hit) begin
      if ((hit_idx == '0) || ($signed(rdata) > best)) begin
        best     <= $signed(rdata);
        best_arg <= hit_idx;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == qtl_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == qtl_pkg::ST_DONE && out_free) begin
      if (act == qtl_pkg::ACT_UPDATE) begin
        out_data.chosen_move <= '0;
        out_data.explored    <= 1'b0;
        out_data.new_value   <= nv;
      end else begin
        if (frac < exploration) begin
          out_data.chosen_move <= qtl_pkg::MOVE_W'(rnd_c);
          out_data.explored    <= 1'b1;
        end else begin
          out_data.chosen_move <= qtl_pkg::MOVE_W'(best_arg);
          out_data.explored    <= 1'b0;
        end
        out_data.new_value <= best;
      end
    end
  end

  qtl_ram #(
    .WIDTH (qtl_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  qtl_arith u_arith (
    .clk       (clk),
    .ctl       (actl),
    .discount  (discount),
    .alpha     (alpha),
    .best      (best),
    .reward    (reward),
    .old_value (rdata),
    .nv        (nv)
  );

endmodule

`default_nettype wire

// ===== rtl/qtl_ram.sv =====
// ----------------------------------------------------------------------------
// qtl_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module qtl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/qtl_arith.sv =====
// ----------------------------------------------------------------------------
// qtl_arith
// Update datapath: discounted target, difference, scaling by the learning
// rate with round half up, and saturating sum with the old entry.
// ----------------------------------------------------------------------------
`default_nettype none

module qtl_arith (
  input  wire logic                                clk,
  input  wire qtl_pkg::qtl_arith_ctl_t             ctl,
  input  wire logic [qtl_pkg::FRAC_W-1:0]          discount,
  input  wire logic [qtl_pkg::FRAC_W-1:0]          alpha,
  input  wire logic signed [qtl_pkg::VALUE_W-1:0]  best,
  input  wire logic signed [qtl_pkg::VALUE_W-1:0]  reward,
  input  wire logic [qtl_pkg::VALUE_W-1:0]         old_value,
  output      logic signed [qtl_pkg::VALUE_W-1:0]  nv
);

  localparam logic signed [48:0] HALF_G = 49'sd32768;
  localparam logic signed [51:0] HALF_A = 52'sd32768;

  logic signed [qtl_pkg::VALUE_W-1:0] curq;
  logic signed [48:0] pg;
  logic signed [33:0] target;
  logic signed [34:0] diff;
  logic signed [51:0] pa;

  logic signed [16:0] disc_s;
  logic signed [16:0] alpha_s;
  logic signed [48:0] pg_rnd;
  logic signed [51:0] pa_rnd;
  logic signed [36:0] sum;

  assign disc_s  = $signed({1'b0, discount});
  assign alpha_s = $signed({1'b0, alpha});

  // floor shifts after adding one half
  assign pg_rnd = (pg + HALF_G) >>> 16;
  assign pa_rnd = (pa + HALF_A) >>> 16;
  assign sum    = 37'(curq) + 37'($signed(pa_rnd[35:0]));

  // one step per enable, register after each multiply
  always_ff @(posedge clk) begin
    if (ctl.load_q) begin
      curq <= $signed(old_value);
      pg   <= 49'(disc_s) * 49'(best);
    end
    if (ctl.load_t) begin
      target <= 34'(reward) + 34'($signed(pg_rnd[32:0]));
    end
    if (ctl.load_d) begin
      diff <= 35'(target) - 35'(curq);
    end
    if (ctl.load_p) begin
      pa <= 52'(alpha_s) * 52'(diff);
    end
    if (ctl.load_n) begin
      if (sum > 37'sh0_7FFF_FFFF) begin
        nv <= 32'sh7FFF_FFFF;
      end else if (sum < -37'sh0_8000_0000) begin
        nv <= 32'sh8000_0000;
      end else begin
        nv <= sum[31:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/qtl_checker.sv =====
// ----------------------------------------------------------------------------
// qtl_checker
// Port-level checks of the Q-learning engine, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qtl_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire qtl_pkg::qtl_out_t          out_data
);

  // table clearing keeps the input closed right after reset
  a_busy_after_reset: assert property (@(posedge clk)
    $past(rst) |-> in_stall)
    else $error("input open right after reset");

  // one item at a time: a taken beat closes the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open on the cycle after an accepted beat");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed or dropped");

endmodule

bind q_table_learner qtl_checker u_qtl_checker (.*);

`default_nettype wire
